### rtl/hlc_pkg.sv
// Package for the handlebar lamp controller: operation codes, register
// indexes, reset values and the flag and lamp structs. No dependencies.
package hlc_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int OP_W            = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int MS_W            = 16;

  localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
  localparam logic [OP_W-1:0] OP_LEFT_PUSH  = 3'd1;
  localparam logic [OP_W-1:0] OP_LEFT_HOLD  = 3'd2;
  localparam logic [OP_W-1:0] OP_RIGHT_PUSH = 3'd3;
  localparam logic [OP_W-1:0] OP_RIGHT_HOLD = 3'd4;
  localparam logic [OP_W-1:0] OP_BOTH_HOLD  = 3'd5;
  localparam logic [OP_W-1:0] OP_POWER_ON   = 3'd6;
  localparam logic [OP_W-1:0] OP_POWER_OFF  = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_SWAP_MAPPING    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENGINE_KILL_MS  = 2'd2;

  localparam logic [MS_W-1:0] BLINK_PERIOD_RESET = 16'd1000;
  localparam logic [MS_W-1:0] ENGINE_KILL_RESET  = 16'd5000;

  typedef struct packed {
    logic system;
    logic main_lights;
    logic high_beam;
    logic left_turn;
    logic right_turn;
    logic position;
  } flags_t;

  typedef struct packed {
    logic engine_enable;
    logic position_lamp;
    logic low_beam;
    logic high_beam_lamp;
    logic brake_lamp;
    logic left_indicator;
    logic right_indicator;
    logic horn_drive;
    logic system_active;
  } lamps_t;

endpackage

### rtl/hlc_in_if.sv
// Input channel of the lamp controller: one event or tick per beat.
// Depends on hlc_pkg for the operation width.
interface hlc_in_if;
  logic                        valid;
  logic                        ready;
  logic [hlc_pkg::OP_W-1:0]    operation;
  logic                        brake_switch;
  logic                        horn_switch;

  modport source (output valid, operation, brake_switch, horn_switch, input ready);
  modport sink   (input valid, operation, brake_switch, horn_switch, output ready);
endinterface

### rtl/hlc_out_if.sv
// Result channel of the lamp controller: all drive levels in one beat.
// No package dependency.
interface hlc_out_if;
  logic valid;
  logic ready;
  logic engine_enable;
  logic position_lamp;
  logic low_beam;
  logic high_beam_lamp;
  logic brake_lamp;
  logic left_indicator;
  logic right_indicator;
  logic horn_drive;
  logic system_active;

  modport source (output valid, engine_enable, position_lamp, low_beam, high_beam_lamp,
                  brake_lamp, left_indicator, right_indicator, horn_drive, system_active,
                  input ready);
  modport sink   (input valid, engine_enable, position_lamp, low_beam, high_beam_lamp,
                  brake_lamp, left_indicator, right_indicator, horn_drive, system_active,
                  output ready);
endinterface

### rtl/hlc_cfg_if.sv
// Configuration write channel: register index and write data per beat.
// Depends on hlc_pkg for the index and data widths.
interface hlc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hlc_pkg::CFG_IDX_W-1:0]     index;
  logic [hlc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/handlebar_light_controller.sv
// Top level of the handlebar lamp controller.
// Depends on hlc_pkg, the three channel interfaces and hlc_step.

// Each input beat carries one operation (a one-millisecond tick or an already
// classified button event) with the current brake and horn switch levels, and
// produces exactly one result beat holding every lamp and engine drive level as
// they stand after that operation. The flag and timer update is a single layer
// of logic written straight into the state registers and the result register,
// so a new beat can be accepted on every clock edge while the input is ready.
// The result register doubles as the output stage; the input is ready whenever
// that register is empty or its beat is being taken in the same cycle, so a
// stalled consumer holds off the producer only while a result is actually
// waiting. The result beat is valid in the cycle after its input beat is
// accepted. The configuration channel is always ready; its registers
// (push/hold swap, blink period, engine-kill duration) should be written only
// while no beat is in flight. Register indexes beyond the list are accepted
// and ignored. TIMER_WIDTH sets the width of the blink phase and kill
// countdown; kill loads saturate at the timer maximum.
module handlebar_light_controller #(
  parameter int TIMER_WIDTH = hlc_pkg::TIMER_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hlc_in_if.sink    in_ch,
  hlc_out_if.source out_ch,
  hlc_cfg_if.sink   cfg_ch
);

  // Configuration registers.
  logic                     swap_mapping_r;
  logic [hlc_pkg::MS_W-1:0] blink_period_ms_r;
  logic [hlc_pkg::MS_W-1:0] engine_kill_ms_r;

  // Controller state.
  hlc_pkg::flags_t          flags_r;
  hlc_pkg::flags_t          flags_nxt;
  logic [TIMER_WIDTH-1:0]   blink_phase_r;
  logic [TIMER_WIDTH-1:0]   blink_phase_nxt;
  logic [TIMER_WIDTH-1:0]   kill_remaining_r;
  logic [TIMER_WIDTH-1:0]   kill_remaining_nxt;

  // Result register.
  logic                     out_valid_r;
  hlc_pkg::lamps_t          lamps_r;
  hlc_pkg::lamps_t          lamps_nxt;

  logic                     in_fire;

  // The configuration port never stalls.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_mapping_r    <= 1'b0;
      blink_period_ms_r <= hlc_pkg::BLINK_PERIOD_RESET;
      engine_kill_ms_r  <= hlc_pkg::ENGINE_KILL_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        hlc_pkg::REG_SWAP_MAPPING:    swap_mapping_r    <= cfg_ch.data[0];
        hlc_pkg::REG_BLINK_PERIOD_MS: blink_period_ms_r <= cfg_ch.data;
        hlc_pkg::REG_ENGINE_KILL_MS:  engine_kill_ms_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // A new beat enters when the result register is empty or draining now.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  hlc_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .operation          (in_ch.operation),
    .brake_switch       (in_ch.brake_switch),
    .horn_switch        (in_ch.horn_switch),
    .swap_mapping       (swap_mapping_r),
    .blink_period_ms    (blink_period_ms_r),
    .engine_kill_ms     (engine_kill_ms_r),
    .flags              (flags_r),
    .blink_phase        (blink_phase_r),
    .kill_remaining     (kill_remaining_r),
    .flags_nxt          (flags_nxt),
    .blink_phase_nxt    (blink_phase_nxt),
    .kill_remaining_nxt (kill_remaining_nxt),
    .lamps              (lamps_nxt)
  );

  // State advances only on an accepted input beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r          <= '0;
      blink_phase_r    <= '0;
      kill_remaining_r <= '0;
    end else if (in_fire) begin
      flags_r          <= flags_nxt;
      blink_phase_r    <= blink_phase_nxt;
      kill_remaining_r <= kill_remaining_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload holds while a result waits; no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      lamps_r <= lamps_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.engine_enable   = lamps_r.engine_enable;
  assign out_ch.position_lamp   = lamps_r.position_lamp;
  assign out_ch.low_beam        = lamps_r.low_beam;
  assign out_ch.high_beam_lamp  = lamps_r.high_beam_lamp;
  assign out_ch.brake_lamp      = lamps_r.brake_lamp;
  assign out_ch.left_indicator  = lamps_r.left_indicator;
  assign out_ch.right_indicator = lamps_r.right_indicator;
  assign out_ch.horn_drive      = lamps_r.horn_drive;
  assign out_ch.system_active   = lamps_r.system_active;

endmodule

### rtl/hlc_step.sv
// Next-state and lamp decode for one controller beat (pure combinational).
// Depends on hlc_pkg for operation codes and the flag and lamp structs.
module hlc_step #(
  parameter int TIMER_WIDTH = hlc_pkg::TIMER_WIDTH_DEF
) (
  input  logic [hlc_pkg::OP_W-1:0]  operation,
  input  logic                      brake_switch,
  input  logic                      horn_switch,
  input  logic                      swap_mapping,
  input  logic [hlc_pkg::MS_W-1:0]  blink_period_ms,
  input  logic [hlc_pkg::MS_W-1:0]  engine_kill_ms,
  input  hlc_pkg::flags_t           flags,
  input  logic [TIMER_WIDTH-1:0]    blink_phase,
  input  logic [TIMER_WIDTH-1:0]    kill_remaining,
  output hlc_pkg::flags_t           flags_nxt,
  output logic [TIMER_WIDTH-1:0]    blink_phase_nxt,
  output logic [TIMER_WIDTH-1:0]    kill_remaining_nxt,
  output hlc_pkg::lamps_t           lamps
);

  // Compare width wide enough for both the timer (plus carry) and the registers.
  localparam int CW = (TIMER_WIDTH + 1 > hlc_pkg::MS_W + 1) ? TIMER_WIDTH + 1
                                                            : hlc_pkg::MS_W + 1;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  logic [TIMER_WIDTH:0]   phase_inc;
  logic                   phase_wrap;
  logic [TIMER_WIDTH-1:0] phase_tick;
  logic [TIMER_WIDTH-1:0] kill_load;
  logic                   do_left;
  logic                   do_right;
  logic                   do_beam;
  logic                   do_main;
  logic                   lit;

  assign phase_inc  = {1'b0, blink_phase} + {{TIMER_WIDTH{1'b0}}, 1'b1};
  assign phase_wrap = phase_inc[TIMER_WIDTH] || (CW'(phase_inc) >= CW'(blink_period_ms));
  assign phase_tick = phase_wrap ? '0 : phase_inc[TIMER_WIDTH-1:0];
  assign kill_load  = (CW'(engine_kill_ms) > CW'(TIMER_MAX)) ? TIMER_MAX
                                                             : TIMER_WIDTH'(engine_kill_ms);

  always_comb begin
    flags_nxt          = flags;
    blink_phase_nxt    = blink_phase;
    kill_remaining_nxt = kill_remaining;
    do_left            = 1'b0;
    do_right           = 1'b0;
    do_beam            = 1'b0;
    do_main            = 1'b0;

    case (operation)
      hlc_pkg::OP_TICK: begin
        blink_phase_nxt = phase_tick;
        if (kill_remaining != '0) begin
          kill_remaining_nxt = kill_remaining - {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
        end
      end
      hlc_pkg::OP_LEFT_PUSH: begin
        if (flags.system && flags.main_lights) begin
          do_left = swap_mapping;
          do_beam = !swap_mapping;
        end
      end
      hlc_pkg::OP_LEFT_HOLD: begin
        if (flags.system) begin
          do_beam = swap_mapping;
          do_left = !swap_mapping;
        end else begin
          flags_nxt.position = !flags.position;
        end
      end
      hlc_pkg::OP_RIGHT_PUSH: begin
        if (flags.system && flags.main_lights) begin
          do_right = swap_mapping;
          do_main  = !swap_mapping;
        end
      end
      hlc_pkg::OP_RIGHT_HOLD: begin
        if (flags.system) begin
          do_main  = swap_mapping;
          do_right = !swap_mapping;
        end
      end
      hlc_pkg::OP_BOTH_HOLD: begin
        if (flags.system) begin
          kill_remaining_nxt = kill_load;
        end
      end
      hlc_pkg::OP_POWER_ON: begin
        if (!flags.system) begin
          flags_nxt = '{system: 1'b1, main_lights: 1'b1, default: 1'b0};
        end
      end
      hlc_pkg::OP_POWER_OFF: begin
        if (flags.system) begin
          flags_nxt = '0;
        end
      end
      default: ;
    endcase

    // At most one toggle is active per beat, so these act on the old flags.
    if (do_left) begin
      if (flags.left_turn) begin
        flags_nxt.left_turn = 1'b0;
      end else if (!flags.right_turn) begin
        flags_nxt.left_turn = 1'b1;
        blink_phase_nxt     = '0;
      end
    end
    if (do_right) begin
      if (flags.right_turn) begin
        flags_nxt.right_turn = 1'b0;
      end else if (!flags.left_turn) begin
        flags_nxt.right_turn = 1'b1;
        blink_phase_nxt      = '0;
      end
    end
    if (do_beam && flags.main_lights) begin
      flags_nxt.high_beam = !flags.high_beam;
    end
    if (do_main) begin
      if (!flags.main_lights) begin
        flags_nxt.main_lights = 1'b1;
      end else begin
        flags_nxt.main_lights = 1'b0;
        flags_nxt.high_beam   = 1'b0;
        flags_nxt.left_turn   = 1'b0;
        flags_nxt.right_turn  = 1'b0;
      end
    end
  end

  assign lit = CW'(blink_phase_nxt) < CW'(blink_period_ms >> 1);

  always_comb begin
    lamps.engine_enable   = flags_nxt.system && (kill_remaining_nxt == '0);
    lamps.position_lamp   = flags_nxt.position || flags_nxt.main_lights;
    lamps.low_beam        = flags_nxt.main_lights && !flags_nxt.high_beam;
    lamps.high_beam_lamp  = flags_nxt.main_lights && flags_nxt.high_beam;
    lamps.brake_lamp      = brake_switch;
    lamps.left_indicator  = flags_nxt.left_turn && lit;
    lamps.right_indicator = flags_nxt.right_turn && lit;
    lamps.horn_drive      = horn_switch;
    lamps.system_active   = flags_nxt.system;
  end

endmodule

### bench/hlc_lamp_checker.sv
// Lamp checker for the handlebar lamp controller: watches the input, result and
// configuration channels, predicts every result beat and compares it.
// Depends on hlc_pkg and the three channel interfaces.
module hlc_lamp_checker
  import hlc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  hlc_in_if     in_ch,
  hlc_out_if    out_ch,
  hlc_cfg_if    cfg_ch,
  output int    fault_count,
  output int    lamps_due
);

  localparam int TW = TIMER_WIDTH_DEF;

  // Shadow copy of the configuration and of the controller state.
  logic          swap_hold;
  logic [MS_W-1:0] shadow_period;
  logic [MS_W-1:0] kill_load;
  flags_t        st;
  logic [TW-1:0] blink_phase;
  logic [TW-1:0] kill_left;

  lamps_t pending_lamps[$];
  int     faults;
  int     results_seen;

  task automatic note_fault(string msg);
    faults++;
    $display("checker: result %0d: %s", results_seen, msg);
  endtask

  task automatic check_lamp(string name, logic want, logic got);
    if (got !== want) begin
      note_fault($sformatf("%s expected %0b got %0b", name, want, got));
    end
  endtask

  function automatic void flip_left();
    if (st.left_turn) begin
      st.left_turn = 1'b0;
    end else if (!st.right_turn) begin
      st.left_turn = 1'b1;
      blink_phase = '0;
    end
  endfunction

  function automatic void flip_right();
    if (st.right_turn) begin
      st.right_turn = 1'b0;
    end else if (!st.left_turn) begin
      st.right_turn = 1'b1;
      blink_phase = '0;
    end
  endfunction

  function automatic void flip_beam();
    if (st.main_lights) begin
      st.high_beam = !st.high_beam;
    end
  endfunction

  function automatic void flip_main();
    if (!st.main_lights) begin
      st.main_lights = 1'b1;
    end else begin
      st.main_lights = 1'b0;
      st.high_beam   = 1'b0;
      st.left_turn   = 1'b0;
      st.right_turn  = 1'b0;
    end
  endfunction

  function automatic void set_power(logic on);
    st = '0;
    st.system      = on;
    st.main_lights = on;
  endfunction

  // Applies one operation to the shadow state and returns the drive levels.
  function automatic lamps_t predict_lamps(logic [OP_W-1:0] op, logic brake, logic horn);
    logic [TW:0] next_phase;
    logic        lit;
    lamps_t      l;
    case (op)
      OP_TICK: begin
        next_phase = {1'b0, blink_phase} + (TW+1)'(1);
        if (next_phase >= {1'b0, shadow_period}) next_phase = '0;
        blink_phase = next_phase[TW-1:0];
        if (kill_left != '0) kill_left = kill_left - TW'(1);
      end
      OP_LEFT_PUSH: begin
        if (st.system && st.main_lights) begin
          if (swap_hold) flip_left(); else flip_beam();
        end
      end
      OP_LEFT_HOLD: begin
        if (st.system) begin
          if (swap_hold) flip_beam(); else flip_left();
        end else begin
          st.position = !st.position;
        end
      end
      OP_RIGHT_PUSH: begin
        if (st.system && st.main_lights) begin
          if (swap_hold) flip_right(); else flip_main();
        end
      end
      OP_RIGHT_HOLD: begin
        if (st.system) begin
          if (swap_hold) flip_main(); else flip_right();
        end
      end
      OP_BOTH_HOLD: begin
        if (st.system) kill_left = kill_load;
      end
      OP_POWER_ON: begin
        if (!st.system) set_power(1'b1);
      end
      default: begin
        if (st.system) set_power(1'b0);
      end
    endcase
    lit = blink_phase < (shadow_period >> 1);
    l.engine_enable   = st.system && (kill_left == '0);
    l.position_lamp   = st.position || st.main_lights;
    l.low_beam        = st.main_lights && !st.high_beam;
    l.high_beam_lamp  = st.main_lights && st.high_beam;
    l.brake_lamp      = brake;
    l.left_indicator  = st.left_turn && lit;
    l.right_indicator = st.right_turn && lit;
    l.horn_drive      = horn;
    l.system_active   = st.system;
    return l;
  endfunction

  always @(posedge clk) begin
    lamps_t want;
    if (!rst_n) begin
      swap_hold     = 1'b0;
      shadow_period = BLINK_PERIOD_RESET;
      kill_load     = ENGINE_KILL_RESET;
      st            = '0;
      blink_phase   = '0;
      kill_left     = '0;
      pending_lamps.delete();
      faults        = 0;
      results_seen  = 0;
    end else begin
      // Results leave before the beat accepted at this same edge is added.
      if (out_ch.valid && out_ch.ready) begin
        if (pending_lamps.size() == 0) begin
          note_fault("result beat with no input beat waiting");
        end else begin
          want = pending_lamps.pop_front();
          check_lamp("engine_enable",   want.engine_enable,   out_ch.engine_enable);
          check_lamp("position_lamp",   want.position_lamp,   out_ch.position_lamp);
          check_lamp("low_beam",        want.low_beam,        out_ch.low_beam);
          check_lamp("high_beam_lamp",  want.high_beam_lamp,  out_ch.high_beam_lamp);
          check_lamp("brake_lamp",      want.brake_lamp,      out_ch.brake_lamp);
          check_lamp("left_indicator",  want.left_indicator,  out_ch.left_indicator);
          check_lamp("right_indicator", want.right_indicator, out_ch.right_indicator);
          check_lamp("horn_drive",      want.horn_drive,      out_ch.horn_drive);
          check_lamp("system_active",   want.system_active,   out_ch.system_active);
        end
        results_seen++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_SWAP_MAPPING:    swap_hold     = cfg_ch.data[0];
          REG_BLINK_PERIOD_MS: shadow_period = cfg_ch.data;
          REG_ENGINE_KILL_MS:  kill_load     = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_lamps.push_back(predict_lamps(in_ch.operation, in_ch.brake_switch,
                                              in_ch.horn_switch));
      end
    end
    fault_count <= faults;
    lamps_due   <= pending_lamps.size();
  end

endmodule

### bench/tb_top.sv
// Testbench top for the handlebar lamp controller: clock, reset, stimulus on the
// input and configuration channels, result back-pressure and the verdict.
// Depends on hlc_pkg, the channel interfaces, the controller and hlc_lamp_checker.
module tb_top;
  import hlc_pkg::*;

  // Register index past the end of the list; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int RANDOM_PHASES   = 13;
  localparam int BEATS_PER_PHASE = 150;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 5;

  logic clk = 1'b0;
  logic rst_n;

  hlc_in_if  in_if();
  hlc_out_if out_if();
  hlc_cfg_if cfg_if();

  int fault_count;
  int lamps_due;

  // When set, neither side inserts idle cycles.
  bit no_idle = 1'b0;
  // Set by the stimulus process to ask the result side for one long stall.
  bit hold_ready_req = 1'b0;

  handlebar_light_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  hlc_lamp_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_ch      (cfg_if),
    .fault_count (fault_count),
    .lamps_due   (lamps_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Gap lengths for both sides: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Ticks dominate, as on the real bike. Power off is kept rare so that most
  // of the run sees the system on, where the button events actually matter.
  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_TICK;
    if (r < 55) return OP_LEFT_PUSH;
    if (r < 65) return OP_LEFT_HOLD;
    if (r < 75) return OP_RIGHT_PUSH;
    if (r < 85) return OP_RIGHT_HOLD;
    if (r < 90) return OP_BOTH_HOLD;
    if (r < 96) return OP_POWER_ON;
    return OP_POWER_OFF;
  endfunction

  // Offers one input beat and returns at the edge where it is accepted. The
  // valid line is left high, so a following beat with no gap keeps it high
  // without lowering and raising it in the same time step.
  task automatic send_beat(logic [OP_W-1:0] op, logic brake, logic horn);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= op;
    in_if.brake_switch <= brake;
    in_if.horn_switch  <= horn;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Stops offering beats and waits until every predicted result has come out.
  // The first edge lets the checker count the beat accepted at the current one.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (lamps_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One configuration beat. The valid line is lowered by the caller once the
  // whole group of writes is done.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // Writes all three registers while the block is idle. The swap bit rides in
  // data bit 0; the upper bits are random, since only bit 0 counts.
  task automatic load_settings(logic swap, logic [MS_W-1:0] period, logic [MS_W-1:0] kill,
                               bit poke_unused);
    logic [CFG_DATA_W-1:0] swap_word;
    drain();
    swap_word = CFG_DATA_W'($urandom);
    swap_word[0] = swap;
    cfg_write(REG_SWAP_MAPPING, swap_word);
    cfg_write(REG_BLINK_PERIOD_MS, period);
    cfg_write(REG_ENGINE_KILL_MS, kill);
    if (poke_unused) cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: ready in random runs with random stalls. On request it holds
  // ready low for a long, counted stretch so that the one-deep output stage
  // fills up and the block must stall its input while beats are still offered.
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_ready_req) begin
        hold_ready_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Hard limit on the run: well beyond the slowest correct run, even with every
  // gap at its longest.
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic            swap;
    logic [MS_W-1:0] period;
    logic [MS_W-1:0] kill;

    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.operation    <= OP_TICK;
    in_if.brake_switch <= 1'b0;
    in_if.horn_switch  <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_SWAP_MAPPING;
    cfg_if.data        <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part with the reset settings: push gives beam and main lights,
    // hold gives the indicators. First the events while the system is off.
    send_beat(OP_TICK,       1'b0, 1'b0);
    send_beat(OP_LEFT_HOLD,  1'b1, 1'b0);  // position light toggles while off
    send_beat(OP_LEFT_PUSH,  1'b0, 1'b1);
    send_beat(OP_RIGHT_HOLD, 1'b1, 1'b1);
    send_beat(OP_BOTH_HOLD,  1'b0, 1'b0);
    send_beat(OP_POWER_OFF,  1'b1, 1'b0);  // already off, nothing happens
    send_beat(OP_POWER_ON,   1'b0, 1'b1);  // main lights on, position cleared
    send_beat(OP_POWER_ON,   1'b1, 1'b1);  // already on, nothing happens
    send_beat(OP_LEFT_PUSH,  1'b0, 1'b0);  // high beam on
    send_beat(OP_LEFT_HOLD,  1'b0, 1'b0);  // left indicator on, phase restarts
    send_beat(OP_RIGHT_HOLD, 1'b1, 1'b0);  // refused while left is on
    send_beat(OP_TICK,       1'b0, 1'b1);
    send_beat(OP_LEFT_HOLD,  1'b0, 1'b0);  // left off
    send_beat(OP_RIGHT_HOLD, 1'b0, 1'b0);  // right on
    send_beat(OP_BOTH_HOLD,  1'b1, 1'b1);  // engine kill starts
    send_beat(OP_TICK,       1'b0, 1'b0);
    send_beat(OP_BOTH_HOLD,  1'b0, 1'b0);  // kill reloads
    send_beat(OP_RIGHT_PUSH, 1'b0, 1'b0);  // main off clears beam and indicator
    send_beat(OP_LEFT_PUSH,  1'b1, 1'b0);  // beam toggle with main off
    send_beat(OP_RIGHT_PUSH, 1'b0, 1'b1);
    send_beat(OP_POWER_OFF,  1'b0, 1'b0);

    // Swapped mapping, a blink period too short to ever light, no kill time.
    load_settings(1'b1, 16'd1, 16'd0, 1'b0);
    send_beat(OP_POWER_ON,   1'b1, 1'b0);
    send_beat(OP_RIGHT_PUSH, 1'b0, 1'b0);  // right indicator, never lit
    send_beat(OP_TICK,       1'b0, 1'b1);
    send_beat(OP_LEFT_PUSH,  1'b0, 1'b0);  // refused while right is on
    send_beat(OP_LEFT_HOLD,  1'b1, 1'b1);  // high beam on
    send_beat(OP_RIGHT_HOLD, 1'b0, 1'b0);  // main lights off
    send_beat(OP_LEFT_HOLD,  1'b0, 1'b0);  // beam toggle with main off
    send_beat(OP_RIGHT_HOLD, 1'b1, 1'b0);  // main lights back on
    send_beat(OP_BOTH_HOLD,  1'b0, 1'b1);  // zero kill time keeps engine on

    // Random phases. The first few pin the register extremes; the rest use
    // short periods and kill times so that blinking and expiry show up often.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin swap = 1'b0; period = 16'd4;     kill = 16'd10;    end
        1: begin swap = 1'b1; period = 16'd2;     kill = 16'd0;     end
        2: begin swap = 1'b0; period = 16'hFFFF;  kill = 16'hFFFF;  end
        3: begin swap = 1'b1; period = 16'd1;     kill = 16'd3;     end
        4: begin swap = 1'b0; period = 16'd0;     kill = 16'd1;     end
        5: begin swap = 1'b1; period = 16'd1000;  kill = 16'd5000;  end
        default: begin
          swap   = 1'($urandom_range(0, 1));
          period = MS_W'($urandom_range(2, 24));
          kill   = MS_W'($urandom_range(0, 40));
        end
      endcase
      load_settings(swap, period, kill, (phase % 4) == 3);
      no_idle = (phase == 2) || (phase == 8);
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if ((phase == 5 || phase == 10) && n == 30) hold_ready_req = 1'b1;
        send_beat(pick_op(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      no_idle = 1'b0;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && lamps_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
